// File: rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stereo peak hold meter.
// ----------------------------------------------------------------------------
package spm_pkg;

   // Fixed field widths of the register port and the registers
   localparam int CFG_DATA_BITS  = 16;
   localparam int CFG_INDEX_BITS = 2;
   localparam int CFG_COUNT_BITS = 8;
   localparam int DECAY_BITS     = 16;

   // 1.0 in Q2.16, the clip threshold
   localparam logic [32:0] FULL_SCALE = 33'd65536;

   // Register reset values
   localparam logic [DECAY_BITS-1:0]     DECAY_RESET     = 16'd62259;
   localparam logic [CFG_COUNT_BITS-1:0] HOLD_RESET      = 8'd60;
   localparam logic [CFG_COUNT_BITS-1:0] CLIP_HOLD_RESET = 8'd30;

   // Register indexes
   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_DECAY_FACTOR    = 2'd0,
      REG_HOLD_TICKS      = 2'd1,
      REG_CLIP_HOLD_TICKS = 2'd2
   } spm_reg_type;

   // Word commands
   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_CLEAR = 1'b1
   } spm_cmd_type;

   // Per-channel update control
   typedef struct packed {
      logic step;   // commit the next state this cycle
      logic clear;  // clear holds and clip, keep the display
   } spm_ctrl_type;

endpackage

// File: rtl/stereo_peak_hold_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_peak_hold_meter_top
// Stereo peak meter with hold, decay and clip indication, one word per tick.
// ----------------------------------------------------------------------------
// Path: an accepted word goes through the input register, then the channel
//   update into the response register; it waits in the input register while
//   the response register is full and not taken.
// Throughput: one word per cycle unless the response side stalls; each channel
//   update is two 18x16 multiplies (display and held decay) and compares
//   between the input register and the response register.
// Reset: synchronous; clears levels, counters and clip flags and loads the
//   register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module stereo_peak_hold_meter_top #(
   parameter int LEVEL_BITS = 18,
   parameter int COUNT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic [LEVEL_BITS-1:0]                req_left_peak,
   input  logic [LEVEL_BITS-1:0]                req_right_peak,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [LEVEL_BITS-1:0]                rsp_left_display,
   output logic [LEVEL_BITS-1:0]                rsp_right_display,
   output logic [LEVEL_BITS-1:0]                rsp_left_held,
   output logic [LEVEL_BITS-1:0]                rsp_right_held,
   output logic                                 rsp_left_clip,
   output logic                                 rsp_right_clip,
   // register write port
   input  logic                                 csr_we,
   input  logic [spm_pkg::CFG_INDEX_BITS-1:0]   csr_index,
   input  logic [spm_pkg::CFG_DATA_BITS-1:0]    csr_wdata
);
   import spm_pkg::*;

   // Registers
   logic [DECAY_BITS-1:0]     decay_ff;
   logic [CFG_COUNT_BITS-1:0] hold_ticks_ff;
   logic [CFG_COUNT_BITS-1:0] clip_ticks_ff;

   // Input register
   logic                  in_vld_ff;
   logic                  cmd_ff;
   logic [LEVEL_BITS-1:0] lpk_ff;
   logic [LEVEL_BITS-1:0] rpk_ff;

   // Response register
   logic                  out_vld_ff;
   logic [LEVEL_BITS-1:0] ldisp_ff, rdisp_ff, lheld_ff, rheld_ff;
   logic                  lclip_ff, rclip_ff;

   logic                  advance;
   spm_ctrl_type          ctrl;
   logic [LEVEL_BITS-1:0] ldisp_in, rdisp_in, lheld_in, rheld_in;
   logic                  lclip_in, rclip_in;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff      <= DECAY_RESET;
         hold_ticks_ff <= HOLD_RESET;
         clip_ticks_ff <= CLIP_HOLD_RESET;
      end else if (csr_we) begin
         unique case (spm_reg_type'(csr_index))
            REG_DECAY_FACTOR:    decay_ff      <= csr_wdata;
            REG_HOLD_TICKS:      hold_ticks_ff <= csr_wdata[CFG_COUNT_BITS-1:0];
            REG_CLIP_HOLD_TICKS: clip_ticks_ff <= csr_wdata[CFG_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the word moves on when the response register is free
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         lpk_ff <= req_left_peak;
         rpk_ff <= req_right_peak;
      end
   end

   // Channel control
   always_comb begin
      ctrl.step  = advance;
      ctrl.clear = (spm_cmd_type'(cmd_ff) == CMD_CLEAR);
   end

   // Channels
   spm_chan #(
      .LEVEL_BITS (LEVEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_left (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .peak        (lpk_ff),
      .decay       (decay_ff),
      .hold_ticks  (hold_ticks_ff),
      .clip_ticks  (clip_ticks_ff),
      .display_nxt (ldisp_in),
      .held_nxt    (lheld_in),
      .clip_nxt    (lclip_in)
   );

   spm_chan #(
      .LEVEL_BITS (LEVEL_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_right (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .peak        (rpk_ff),
      .decay       (decay_ff),
      .hold_ticks  (hold_ticks_ff),
      .clip_ticks  (clip_ticks_ff),
      .display_nxt (rdisp_in),
      .held_nxt    (rheld_in),
      .clip_nxt    (rclip_in)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ldisp_ff <= ldisp_in;
         rdisp_ff <= rdisp_in;
         lheld_ff <= lheld_in;
         rheld_ff <= rheld_in;
         lclip_ff <= lclip_in;
         rclip_ff <= rclip_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_left_display  = ldisp_ff;
   assign rsp_right_display = rdisp_ff;
   assign rsp_left_held     = lheld_ff;
   assign rsp_right_held    = rheld_ff;
   assign rsp_left_clip     = lclip_ff;
   assign rsp_right_clip    = rclip_ff;

   // Checks
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      advance && (spm_cmd_type'(cmd_ff) == CMD_CLEAR) |=>
         !rsp_left_clip && !rsp_right_clip &&
         (rsp_left_held == '0) && (rsp_right_held == '0))
      else $error("clear word left a hold or clip flag set");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && in_vld_ff)
      else $error("request stalled with response side free");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("word advanced without a response");

endmodule

// File: rtl/spm_chan.sv
// ----------------------------------------------------------------------------
// spm_chan
// One meter channel: display, held peak and clip ballistics with their state.
// ----------------------------------------------------------------------------
module spm_chan #(
   parameter int LEVEL_BITS = 18,
   parameter int COUNT_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  spm_pkg::spm_ctrl_type                  ctrl,
   input  logic [LEVEL_BITS-1:0]                  peak,
   input  logic [spm_pkg::DECAY_BITS-1:0]         decay,
   input  logic [spm_pkg::CFG_COUNT_BITS-1:0]     hold_ticks,
   input  logic [spm_pkg::CFG_COUNT_BITS-1:0]     clip_ticks,
   output logic [LEVEL_BITS-1:0]                  display_nxt,
   output logic [LEVEL_BITS-1:0]                  held_nxt,
   output logic                                   clip_nxt
);
   import spm_pkg::*;

   localparam int PROD_BITS = LEVEL_BITS + DECAY_BITS;

   logic [LEVEL_BITS-1:0] disp_ff, disp_in;
   logic [LEVEL_BITS-1:0] hold_ff, hold_in;
   logic [COUNT_BITS-1:0] hcnt_ff, hcnt_in;
   logic [COUNT_BITS-1:0] ccnt_ff, ccnt_in;
   logic                  clip_ff, clip_in;

   logic [PROD_BITS-1:0]  disp_prod;
   logic [PROD_BITS-1:0]  hold_prod;
   logic [COUNT_BITS-1:0] hold_reload;
   logic [COUNT_BITS-1:0] clip_reload;
   logic                  over;

   // Reload values saturate at the counter range
   generate
      if (COUNT_BITS >= CFG_COUNT_BITS) begin : g_wide_cnt
         assign hold_reload = COUNT_BITS'(hold_ticks);
         assign clip_reload = COUNT_BITS'(clip_ticks);
      end else begin : g_narrow_cnt
         assign hold_reload = (|hold_ticks[CFG_COUNT_BITS-1:COUNT_BITS]) ?
                              {COUNT_BITS{1'b1}} : hold_ticks[COUNT_BITS-1:0];
         assign clip_reload = (|clip_ticks[CFG_COUNT_BITS-1:COUNT_BITS]) ?
                              {COUNT_BITS{1'b1}} : clip_ticks[COUNT_BITS-1:0];
      end
   endgenerate

   // Decay products, truncated Q0.16 scaling
   assign disp_prod = PROD_BITS'(disp_ff) * PROD_BITS'(decay);
   assign hold_prod = PROD_BITS'(hold_ff) * PROD_BITS'(decay);

   assign over = 33'(peak) > FULL_SCALE;

   // Next state
   always_comb begin
      disp_in = disp_ff;
      hold_in = hold_ff;
      hcnt_in = hcnt_ff;
      ccnt_in = ccnt_ff;
      clip_in = clip_ff;
      if (ctrl.clear) begin
         hold_in = '0;
         hcnt_in = '0;
         ccnt_in = '0;
         clip_in = 1'b0;
      end else begin
         // display: rise at once, else decay
         if (peak > disp_ff) disp_in = peak;
         else                disp_in = disp_prod[PROD_BITS-1:DECAY_BITS];

         // held peak: rise and reload, count down, then decay
         if (peak > hold_ff) begin
            hold_in = peak;
            hcnt_in = hold_reload;
         end else if (hcnt_ff != '0) begin
            hcnt_in = hcnt_ff - 1'b1;
         end else begin
            hold_in = hold_prod[PROD_BITS-1:DECAY_BITS];
         end

         // clip indication
         if (over) begin
            clip_in = 1'b1;
            ccnt_in = clip_reload;
         end else if (ccnt_ff != '0) begin
            ccnt_in = ccnt_ff - 1'b1;
         end else begin
            clip_in = 1'b0;
         end
      end
   end

   assign display_nxt = disp_in;
   assign held_nxt    = hold_in;
   assign clip_nxt    = clip_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff <= '0;
         hold_ff <= '0;
         hcnt_ff <= '0;
         ccnt_ff <= '0;
         clip_ff <= 1'b0;
      end else if (ctrl.step) begin
         disp_ff <= disp_in;
         hold_ff <= hold_in;
         hcnt_ff <= hcnt_in;
         ccnt_ff <= ccnt_in;
         clip_ff <= clip_in;
      end
   end

endmodule
